/* sv/bph_pkg.sv */
// ---------------------------------------------------------------------------
// bph_pkg
// Shared types and constants for the bounded probe hash table.
// ---------------------------------------------------------------------------
package bph_pkg;

    localparam int TABLE_LOG2_DEF = 12;
    localparam int KEY_W          = 32;
    localparam int SLOT_W         = 12;
    localparam int LIMIT_W        = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [LIMIT_W-1:0] MAX_PROBES      = 7'd64;
    localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST = 7'd8;
    localparam logic [KEY_W-1:0]   HASH_MULT_RST   = 32'h9E37_79B9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT   = 1'b1;

    typedef enum logic [1:0] {
        OP_FIND  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic              inserted;
    } t_rsp;

endpackage

/* sv/bph_ram.sv */
// ---------------------------------------------------------------------------
// bph_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bph_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bph_hash.sv */
// ---------------------------------------------------------------------------
// bph_hash
// Multiplicative hash: home slot is the top bits of key * multiplier mod 2^32.
// ---------------------------------------------------------------------------
module bph_hash #(
    parameter int TABLE_LOG2 = bph_pkg::TABLE_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [bph_pkg::KEY_W-1:0]   i_key,
    input  logic [bph_pkg::KEY_W-1:0]   i_mult,
    output logic [TABLE_LOG2-1:0]       o_home
);

    logic [bph_pkg::KEY_W-1:0] prod;
    logic [TABLE_LOG2-1:0]     r_home;

    // low 32 bits of the product only
    assign prod = i_key * i_mult;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_home <= prod[bph_pkg::KEY_W-1 -: TABLE_LOG2];
        end
    end

    assign o_home = r_home;

endmodule

/* sv/bph_probe.sv */
// ---------------------------------------------------------------------------
// bph_probe
// Request sequencer: slot sweep, probe loop over the slot RAM, result register.
// ---------------------------------------------------------------------------
module bph_probe #(
    parameter int TABLE_LOG2 = bph_pkg::TABLE_LOG2_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  bph_pkg::t_req                 i_req,
    output logic                          o_stall,
    output logic                          o_valid,
    output bph_pkg::t_rsp                 o_rsp,
    input  logic                          i_stall,
    input  logic [bph_pkg::LIMIT_W-1:0]   i_probe_limit,
    output logic                          o_hash_en,
    output logic [bph_pkg::KEY_W-1:0]     o_hash_key,
    input  logic [TABLE_LOG2-1:0]         i_home,
    output logic                          o_ram_we,
    output logic [TABLE_LOG2-1:0]         o_ram_waddr,
    output logic [bph_pkg::KEY_W:0]       o_ram_wdata,
    output logic [TABLE_LOG2-1:0]         o_ram_raddr,
    input  logic [bph_pkg::KEY_W:0]       i_ram_rdata
);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    localparam int LW = bph_pkg::LIMIT_W;

    t_state                   r_state, n_state;
    logic [TABLE_LOG2-1:0]    r_sweep_addr, n_sweep_addr;
    logic                     r_report, n_report;
    logic                     r_out_valid, n_out_valid;
    logic                     r_rd_vld, n_rd_vld;
    bph_pkg::t_op             r_op, n_op;
    logic [bph_pkg::KEY_W-1:0] r_key, n_key;
    logic [LW-1:0]            r_lim, n_lim;
    logic [LW-1:0]            r_chk, n_chk;
    logic [TABLE_LOG2-1:0]    r_chk_pos, n_chk_pos;
    logic                     r_found, n_found;
    logic                     r_empty, n_empty;
    logic [TABLE_LOG2-1:0]    r_res_pos, n_res_pos;
    bph_pkg::t_rsp            r_out, n_out;

    logic                     accept;
    logic                     done_fire;
    logic [TABLE_LOG2-1:0]    iss_addr;
    logic [TABLE_LOG2-1:0]    ins_pos;
    logic [LW-1:0]            eff_lim;
    logic [31:0]              res_ext;
    logic [31:0]              ins_ext;
    logic                     slot_used;
    logic [bph_pkg::KEY_W-1:0] slot_key;

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign done_fire = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign iss_addr  = r_rd_vld ? r_chk_pos + TABLE_LOG2'(1) : i_home;
    // all probed slots occupied: overwrite the home slot
    assign ins_pos   = r_empty ? r_res_pos : i_home;
    assign res_ext   = 32'(r_res_pos);
    assign ins_ext   = 32'(ins_pos);
    assign slot_used = i_ram_rdata[bph_pkg::KEY_W];
    assign slot_key  = i_ram_rdata[bph_pkg::KEY_W-1:0];

    always_comb begin
        if (i_probe_limit == '0) begin
            eff_lim = LW'(1);
        end else if (i_probe_limit > bph_pkg::MAX_PROBES) begin
            eff_lim = bph_pkg::MAX_PROBES;
        end else begin
            eff_lim = i_probe_limit;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_report     = r_report;
        n_out_valid  = r_out_valid && i_stall;
        n_rd_vld     = r_rd_vld;
        n_op         = r_op;
        n_key        = r_key;
        n_lim        = r_lim;
        n_chk        = r_chk;
        n_chk_pos    = r_chk_pos;
        n_found      = r_found;
        n_empty      = r_empty;
        n_res_pos    = r_res_pos;
        n_out        = r_out;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_sweep_addr;
        o_ram_wdata  = '0;

        case (r_state)
            ST_SWEEP: begin
                o_ram_we     = 1'b1;
                n_sweep_addr = r_sweep_addr + TABLE_LOG2'(1);
                if (r_sweep_addr == '1) begin
                    n_state = r_report ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_op         = i_req.op;
                    n_key        = i_req.key;
                    n_lim        = eff_lim;
                    n_found      = 1'b0;
                    n_empty      = 1'b0;
                    n_sweep_addr = '0;
                    n_report     = 1'b1;
                    case (i_req.op)
                        bph_pkg::OP_FIND,
                        bph_pkg::OP_ADD:   n_state = ST_HASH;
                        bph_pkg::OP_CLEAR: n_state = ST_SWEEP;
                        default:           n_state = ST_DONE;
                    endcase
                end
            end
            ST_HASH: begin
                n_rd_vld = 1'b0;
                n_chk    = '0;
                n_state  = ST_PROBE;
            end
            ST_PROBE: begin
                // one read issued per cycle, data of the previous read checked
                n_chk_pos = iss_addr;
                n_rd_vld  = 1'b1;
                if (r_rd_vld) begin
                    n_res_pos = r_chk_pos;
                    if (!slot_used) begin
                        n_empty = 1'b1;
                        n_state = ST_DONE;
                    end else if (slot_key == r_key) begin
                        n_found = 1'b1;
                        n_state = ST_DONE;
                    end else if (r_chk == r_lim - LW'(1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_chk = r_chk + LW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (done_fire) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_state     = ST_IDLE;
                    if (r_found) begin
                        n_out.hit  = 1'b1;
                        n_out.slot = res_ext[bph_pkg::SLOT_W-1:0];
                    end else if (r_op == bph_pkg::OP_ADD) begin
                        o_ram_we       = 1'b1;
                        o_ram_waddr    = ins_pos;
                        o_ram_wdata    = {1'b1, r_key};
                        n_out.slot     = ins_ext[bph_pkg::SLOT_W-1:0];
                        n_out.evicted  = !r_empty;
                        n_out.inserted = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_report     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_report     <= n_report;
            r_out_valid  <= n_out_valid;
            r_rd_vld     <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_lim     <= n_lim;
        r_chk     <= n_chk;
        r_chk_pos <= n_chk_pos;
        r_found   <= n_found;
        r_empty   <= n_empty;
        r_res_pos <= n_res_pos;
        r_out     <= n_out;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_out;
    assign o_hash_en   = (r_state == ST_HASH);
    assign o_hash_key  = r_key;
    assign o_ram_raddr = iss_addr;

endmodule

/* sv/bounded_probe_hash_table_top.sv */
// ---------------------------------------------------------------------------
// bounded_probe_hash_table_top
// Linear probing hash table of 32-bit keys with a bounded probe length.
// ---------------------------------------------------------------------------
// Request channel: i_valid / o_stall carry i_req (op, key); a request is taken
// on a rising edge with i_valid high and o_stall low. Response channel:
// o_valid / i_stall carry o_rsp (hit, slot, evicted, inserted), one response
// per request, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is the probe limit, index 1 the hash multiplier. Write only while
// idle.
// Find/add register the home slot from the hash, then examine slots from there
// through the slot RAM read port, at most the probe limit of them (1 to 64),
// stopping at a match or an empty slot; then an add that missed writes its key
// and the response is registered. Clear writes one slot per cycle.
// After reset every slot of the slot RAM is cleared with o_stall high.
// One request is in flight at a time; the next is taken while a response
// waits in the output register. While the receiver stalls a finished request
// holds until the output register drains.
// ---------------------------------------------------------------------------
module bounded_probe_hash_table_top #(
    parameter int TABLE_LOG2 = bph_pkg::TABLE_LOG2_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  bph_pkg::t_req                    i_req,
    output logic                             o_stall,
    output logic                             o_valid,
    output bph_pkg::t_rsp                    o_rsp,
    input  logic                             i_stall,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bph_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bph_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [bph_pkg::LIMIT_W-1:0] r_probe_limit;
    logic [bph_pkg::KEY_W-1:0]   r_hash_mult;

    logic                        hash_en;
    logic [bph_pkg::KEY_W-1:0]   hash_key;
    logic [TABLE_LOG2-1:0]       home;
    logic                        ram_we;
    logic [TABLE_LOG2-1:0]       ram_waddr;
    logic [bph_pkg::KEY_W:0]     ram_wdata;
    logic [TABLE_LOG2-1:0]       ram_raddr;
    logic [bph_pkg::KEY_W:0]     ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_limit <= bph_pkg::PROBE_LIMIT_RST;
            r_hash_mult   <= bph_pkg::HASH_MULT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bph_pkg::CFG_PROBE_LIMIT: r_probe_limit <= i_cfg_data[bph_pkg::LIMIT_W-1:0];
                bph_pkg::CFG_HASH_MULT:   r_hash_mult   <= i_cfg_data[bph_pkg::KEY_W-1:0];
                default: ;
            endcase
        end
    end

    bph_hash #(
        .TABLE_LOG2 (TABLE_LOG2)
    ) u_hash (
        .i_clk  (i_clk),
        .i_en   (hash_en),
        .i_key  (hash_key),
        .i_mult (r_hash_mult),
        .o_home (home)
    );

    // slot word: valid flag on top of the key
    bph_ram #(
        .WIDTH (bph_pkg::KEY_W + 1),
        .DEPTH (2 ** TABLE_LOG2)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bph_probe #(
        .TABLE_LOG2 (TABLE_LOG2)
    ) u_probe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_req         (i_req),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_rsp         (o_rsp),
        .i_stall       (i_stall),
        .i_probe_limit (r_probe_limit),
        .o_hash_en     (hash_en),
        .o_hash_key    (hash_key),
        .i_home        (home),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

endmodule
